// ===== src/hmrp_pkg.sv =====
// Package for the hashed modulo replica placement block.
// Holds the field widths, the pipeline geometry, the slot type of the modulo
// stages and the rotate helper. No dependencies.
package hmrp_pkg;

    localparam int MAX_REPLICAS  = 16;
    localparam int ID_W          = 64;
    localparam int CNT_W         = 5;
    localparam int NUM_W         = 4;
    localparam int SRV_W         = 16;
    localparam int IN_TDATA_W    = 72;
    localparam int OUT_TDATA_W   = 24;
    localparam int MOD_STEP_BITS = 8;
    localparam int MOD_STAGES    = ID_W / MOD_STEP_BITS;

    // lookup3 start value for an 8-byte key with zero initial value.
    localparam logic [31:0] HASH_INIT = 32'hdeadbeef + 32'd8;

    // One item as it moves through the modulo stages.
    typedef struct packed {
        logic             vld;
        logic [ID_W-1:0]  dividend;
        logic [SRV_W-1:0] rem;
        logic [CNT_W-1:0] cnt;
    } t_mod_slot;

    function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned k);
        rotl32 = (x << k) | (x >> (32 - k));
    endfunction

endpackage

// ===== src/hashed_modulo_replica_placement.sv =====
// Top level of the hashed modulo replica placement block.
// Depends on hmrp_pkg and hmrp_mod_stage.
//
// Each object id is hashed with the lookup3 final mix over its eight bytes,
// the 64-bit hash is reduced modulo the server count, and one result item per
// replica follows with consecutive server indices, the last one marked by
// tlast. The hash takes three pipeline stages, the modulo eight more and the
// replica emitter one. A new item can be accepted every cycle while the
// pipeline is not stalled by the output; the sustained rate is set by the
// output port, which sends one result per cycle while m_tready is high, so an
// item asking for R replicas occupies the output for max(R,1) result items
// (at most 16). Write the server count only while the block is idle.
module hashed_modulo_replica_placement import hmrp_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [SRV_W-1:0]       i_cfg_wdata,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    // [63:0] object_id, [68:64] replica_count, [71:69] zero
    input  logic [IN_TDATA_W-1:0]  s_tdata,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    // [15:0] server_index, [19:16] replica_number, [23:20] zero
    output logic [OUT_TDATA_W-1:0] m_tdata,
    output logic                   m_tlast
);

    logic [SRV_W-1:0] r_n_servers;
    logic             en;
    logic             take;
    logic             em_last;

    // Server count register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_n_servers <= SRV_W'(1);
        end else if (i_cfg_we) begin
            r_n_servers <= i_cfg_wdata;
        end
    end

    // Hash stage registers.
    logic             r_h1_vld, r_h2_vld, r_h3_vld;
    logic [31:0]      r_a1, r_b1, r_c1, r_a2, r_b2, r_c2, r_b3, r_c3;
    logic [CNT_W-1:0] r_cnt1, r_cnt2, r_cnt3;
    logic [31:0]      n_a1, n_b1, n_c1, n_a2, n_b2, n_c2, n_b3, n_c3;
    logic [CNT_W-1:0] n_cnt1;

    // Stage one: key add, count saturation, first two mix steps.
    always_comb begin
        logic [31:0] a, b, c;
        logic [CNT_W-1:0] cnt;
        a = HASH_INIT + s_tdata[31:0];
        b = HASH_INIT + s_tdata[63:32];
        c = HASH_INIT;
        c = (c ^ b) - rotl32(b, 14);
        a = (a ^ c) - rotl32(c, 11);
        cnt = s_tdata[68:64];
        if (cnt == '0) begin
            cnt = CNT_W'(1);
        end else if (cnt > CNT_W'(MAX_REPLICAS)) begin
            cnt = CNT_W'(MAX_REPLICAS);
        end
        n_a1 = a; n_b1 = b; n_c1 = c; n_cnt1 = cnt;
    end

    // Stage two: next three mix steps.
    always_comb begin
        logic [31:0] a, b, c;
        a = r_a1; b = r_b1; c = r_c1;
        b = (b ^ a) - rotl32(a, 25);
        c = (c ^ b) - rotl32(b, 16);
        a = (a ^ c) - rotl32(c, 4);
        n_a2 = a; n_b2 = b; n_c2 = c;
    end

    // Stage three: last two mix steps.
    always_comb begin
        logic [31:0] b, c;
        b = (r_b2 ^ r_a2) - rotl32(r_a2, 14);
        c = (r_c2 ^ b) - rotl32(b, 24);
        n_b3 = b; n_c3 = c;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h1_vld <= 1'b0;
            r_h2_vld <= 1'b0;
            r_h3_vld <= 1'b0;
        end else if (en) begin
            r_h1_vld <= s_tvalid;
            r_h2_vld <= r_h1_vld;
            r_h3_vld <= r_h2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a1 <= n_a1; r_b1 <= n_b1; r_c1 <= n_c1; r_cnt1 <= n_cnt1;
            r_a2 <= n_a2; r_b2 <= n_b2; r_c2 <= n_c2; r_cnt2 <= r_cnt1;
            r_b3 <= n_b3; r_c3 <= n_c3; r_cnt3 <= r_cnt2;
        end
    end

    // Modulo pipeline over the 64-bit hash, secondary hash in the high half.
    t_mod_slot slots [MOD_STAGES+1];

    always_comb begin
        slots[0].vld      = r_h3_vld;
        slots[0].dividend = {r_b3, r_c3};
        slots[0].rem      = '0;
        slots[0].cnt      = r_cnt3;
    end

    for (genvar g = 0; g < MOD_STAGES; g++) begin : g_mod
        hmrp_mod_stage u_stage (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_en        (en),
            .i_n_servers (r_n_servers),
            .i_slot      (slots[g]),
            .o_slot      (slots[g+1])
        );
    end

    // Replica emitter, which is also the output register.
    logic             r_em_vld;
    logic [SRV_W-1:0] r_em_srv;
    logic [NUM_W-1:0] r_em_num;
    logic [CNT_W-1:0] r_em_cnt;
    logic [SRV_W:0]   srv_inc;

    assign em_last  = ({1'b0, r_em_num} + CNT_W'(1)) == r_em_cnt;
    assign take     = !r_em_vld || (m_tready && em_last);
    assign en       = !slots[MOD_STAGES].vld || take;
    assign s_tready = en;
    assign srv_inc  = {1'b0, r_em_srv} + (SRV_W+1)'(1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_em_vld <= 1'b0;
        end else if (take) begin
            r_em_vld <= slots[MOD_STAGES].vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_em_srv <= (r_n_servers == '0) ? '0 : slots[MOD_STAGES].rem;
            r_em_num <= '0;
            r_em_cnt <= slots[MOD_STAGES].cnt;
        end else if (m_tready) begin
            // Next replica goes to the next server, wrapping at the count.
            if (r_n_servers == '0 || srv_inc == {1'b0, r_n_servers}) begin
                r_em_srv <= '0;
            end else begin
                r_em_srv <= srv_inc[SRV_W-1:0];
            end
            r_em_num <= r_em_num + NUM_W'(1);
        end
    end

    assign m_tvalid = r_em_vld;
    assign m_tlast  = em_last;
    assign m_tdata  = {(OUT_TDATA_W-NUM_W-SRV_W)'(0), r_em_num, r_em_srv};

endmodule

// ===== src/hmrp_mod_stage.sv =====
// One slice of the pipelined modulo unit: eight restoring steps per stage.
// Depends on hmrp_pkg.
module hmrp_mod_stage import hmrp_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [SRV_W-1:0] i_n_servers,
    input  t_mod_slot        i_slot,
    output t_mod_slot        o_slot
);

    t_mod_slot r_slot;
    t_mod_slot n_slot;

    // Shift the top dividend bits into the remainder one at a time.
    always_comb begin
        logic [SRV_W:0] t;
        logic [SRV_W-1:0] rem;
        rem = i_slot.rem;
        for (int k = 0; k < MOD_STEP_BITS; k++) begin
            t = {rem, i_slot.dividend[ID_W-1-k]};
            if (t >= {1'b0, i_n_servers}) begin
                t = t - {1'b0, i_n_servers};
            end
            rem = t[SRV_W-1:0];
        end
        n_slot          = i_slot;
        n_slot.rem      = rem;
        n_slot.dividend = i_slot.dividend << MOD_STEP_BITS;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot.vld <= 1'b0;
        end else if (i_en) begin
            r_slot <= n_slot;
        end
    end

    assign o_slot = r_slot;

endmodule

// ===== src/hmrp_checker.sv =====
// Port-level checker for the hashed modulo replica placement block.
// Depends on hmrp_pkg; bound to the top level at the end of this file.
module hmrp_checker import hmrp_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tlast
);

    // A stalled result item stays offered.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result item dropped while stalled");

    // Nothing is offered right after reset.
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_tvalid)
        else $error("result item offered after reset");

    // Within a run the replica numbers count up without gaps.
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tready && !m_tlast |=>
            m_tvalid && m_tdata[19:16] == $past(m_tdata[19:16]) + 4'd1)
        else $error("replica run broken");

    // After the last item of a run, the next run starts at replica zero.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tready && m_tlast |=> !m_tvalid || m_tdata[19:16] == 4'd0)
        else $error("run does not start at replica zero");

    // The highest replica number always closes its run.
    a_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tdata[19:16] == 4'd15 |-> m_tlast)
        else $error("run longer than the replica limit");

endmodule

bind hashed_modulo_replica_placement hmrp_checker u_hmrp_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// ===== verif/hashed_modulo_replica_placement_test.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the hashed modulo replica placement block.
// Depends on hmrp_pkg and the block's top level; predicts every replica item
// from the lookup3 hash and modulo placement and compares each one in order.
module hashed_modulo_replica_placement_test;
    import hmrp_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        logic [SRV_W-1:0] server;
        logic [NUM_W-1:0] replica;
        logic             last;
    } t_placement;

    // One directed row: id, count, and an optional typed-in first server.
    typedef struct {
        logic [ID_W-1:0]  id;
        logic [CNT_W-1:0] count;
        bit               known;
        logic [SRV_W-1:0] first_server;
    } t_directed_row;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   i_cfg_we = 1'b0;
    logic [SRV_W-1:0]       i_cfg_wdata = '0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;
    logic                   m_tlast;

    t_placement       placements_due[$];
    logic [SRV_W-1:0] server_count = 16'd1;
    int               failures = 0;
    int               results_seen = 0;
    int               items_sent = 0;
    int               cycles = 0;
    int               stall_phase = 0;

    hashed_modulo_replica_placement uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic [31:0] rot_left(logic [31:0] x, int k);
        return (x << k) | (x >> (32 - k));
    endfunction

    // lookup3 final mix over an 8-byte key; c in the low half, b in the high.
    function automatic logic [63:0] lookup3_of_id(logic [63:0] id);
        logic [31:0] a, b, c;
        a = 32'hdeadbeef + 32'd8 + id[31:0];
        b = 32'hdeadbeef + 32'd8 + id[63:32];
        c = 32'hdeadbeef + 32'd8;
        c ^= b; c -= rot_left(b, 14);
        a ^= c; a -= rot_left(c, 11);
        b ^= a; b -= rot_left(a, 25);
        c ^= b; c -= rot_left(b, 16);
        a ^= c; a -= rot_left(c, 4);
        b ^= a; b -= rot_left(a, 14);
        c ^= b; c -= rot_left(b, 24);
        return {b, c};
    endfunction

    // Queue the replica items that one object produces.
    task automatic predict_placement(logic [ID_W-1:0] id, logic [CNT_W-1:0] count);
        int         n;
        logic [63:0] srv;
        t_placement p;
        n = (count == 0) ? 1 : (count > MAX_REPLICAS ? MAX_REPLICAS : count);
        srv = (server_count != 0) ? lookup3_of_id(id) % server_count : 64'd0;
        for (int i = 0; i < n; i++) begin
            if (i > 0) srv = (server_count != 0) ? (srv + 1) % server_count : 64'd0;
            p.server = srv[SRV_W-1:0];
            p.replica = i[NUM_W-1:0];
            p.last = (i == n - 1);
            placements_due.push_back(p);
        end
    endtask

    // Send one object; sender gaps are handled by the caller. A typed-in
    // first server, where given, is what the first replica item must show.
    task automatic send_object(logic [ID_W-1:0] id, logic [CNT_W-1:0] count,
                               bit known = 1'b0, logic [SRV_W-1:0] first_server = '0);
        int due_mark;
        due_mark = placements_due.size();
        s_tvalid <= 1'b1;
        s_tdata <= {3'b000, count, id};
        predict_placement(id, count);
        if (known) placements_due[due_mark].server = first_server;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic idle_sender(int gap);
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (placements_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_server_count(logic [SRV_W-1:0] value);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        server_count = value;
        @(posedge i_clk);
    endtask

    // Random object run in bursts with random gaps.
    task automatic random_objects(int total);
        int burst;
        logic [ID_W-1:0]  id;
        logic [CNT_W-1:0] count;
        while (total > 0) begin
            burst = $urandom_range(1, 8);
            while (burst > 0 && total > 0) begin
                id = {$urandom, $urandom};
                case ($urandom_range(0, 9))
                    0: count = 5'd0;
                    1: count = CNT_W'($urandom_range(17, 31));
                    2: count = 5'd16;
                    default: count = CNT_W'($urandom_range(1, 4));
                endcase
                send_object(id, count);
                burst--;
                total--;
            end
            if ($urandom_range(0, 2) != 0) idle_sender($urandom_range(1, 6));
        end
    endtask

    // Receiver stall pattern: a phase with no stalls, then random stalls.
    always @(posedge i_clk) begin
        stall_phase <= (stall_phase + 1) % 300;
        if (stall_phase < 60) m_tready <= 1'b1;
        else m_tready <= ($urandom_range(0, 3) != 0);
    end

    // Compare each accepted replica item with the oldest prediction.
    always @(posedge i_clk) begin
        t_placement want;
        cycles <= cycles + 1;
        if (i_rst_n && m_tvalid && m_tready) begin
            results_seen <= results_seen + 1;
            if (placements_due.size() == 0) begin
                $display("%0t: unexpected item server=%0d replica=%0d last=%0b",
                         $time, m_tdata[15:0], m_tdata[19:16], m_tlast);
                failures <= failures + 1;
            end else begin
                want = placements_due.pop_front();
                if (m_tdata[15:0] !== want.server || m_tdata[19:16] !== want.replica
                        || m_tlast !== want.last || m_tdata[23:20] !== 4'd0) begin
                    $display("%0t: expected server=%0d replica=%0d last=%0b, got %0d %0d %0b",
                             $time, want.server, want.replica, want.last,
                             m_tdata[15:0], m_tdata[19:16], m_tlast);
                    failures <= failures + 1;
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout with %0d items outstanding", placements_due.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        t_directed_row rows[$];
        // With one server every index is zero, so the first server is known.
        rows.push_back('{64'd0, 5'd1, 1'b1, 16'd0});
        rows.push_back('{64'hFFFF_FFFF_FFFF_FFFF, 5'd0, 1'b1, 16'd0});
        rows.push_back('{64'h8000_0000_0000_0001, 5'd16, 1'b1, 16'd0});
        rows.push_back('{64'h0123_4567_89AB_CDEF, 5'd31, 1'b1, 16'd0});
        rows.push_back('{64'hAAAA_AAAA_5555_5555, 5'd3, 1'b1, 16'd0});

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[r])
            send_object(rows[r].id, rows[r].count, rows[r].known, rows[r].first_server);

        // Extremes of the server count, including zero servers.
        write_server_count(16'd65535);
        foreach (rows[r]) send_object(rows[r].id, rows[r].count);
        write_server_count(16'd0);
        send_object(64'h0000_0000_FFFF_FFFF, 5'd4, 1'b1, 16'd0);
        send_object(64'hFFFF_FFFF_0000_0000, 5'd17, 1'b1, 16'd0);
        write_server_count(16'd2);
        foreach (rows[r]) send_object(rows[r].id, rows[r].count);

        // Random phases across several settings.
        write_server_count(16'd7);
        random_objects(40);
        // The sender holds off until every outstanding item has arrived.
        wait_drained();
        random_objects(20);
        write_server_count(16'($urandom_range(1, 65535)));
        random_objects(50);
        write_server_count(16'd65535);
        random_objects(30);
        write_server_count(16'd1);
        random_objects(15);

        wait_drained();
        $display("Sent %0d objects, checked %0d replica items across server counts",
                 items_sent, results_seen);
        $display("including zero, one, two, seven, a random value and 65535.");
        if (failures == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end
endmodule
